[rtl/plb_pkg.sv]
package plb_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  // room for position compares against length + 1
  localparam int CMP_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SHOW   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      pos;
    logic [LEN_W-1:0]      len;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

endpackage

[rtl/plb_cell.sv]
module plb_cell
  import plb_pkg::*;
(
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] ins_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  input  logic signed [DATA_W-1:0] head_value,
  output logic signed [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     below_pos;
  logic                     at_pos;
  logic                     not_tail;

  assign below_pos = idx < cmd.pos;
  assign at_pos    = idx == cmd.pos;
  assign not_tail  = (LEN_W'(idx) + LEN_W'(1)) < cmd.len;

  always_comb begin
    value_nxt = value_r;
    unique case (cmd.op)
      OP_HOLD: value_nxt = value_r;
      OP_INSERT: begin
        if (at_pos) begin
          value_nxt = ins_value;
        end else if (!below_pos) begin
          value_nxt = left_value;
        end
      end
      OP_DELETE: begin
        if (!below_pos) begin
          value_nxt = right_value;
        end
      end
      // tail of the list wraps around to the head
      OP_ROTATE: value_nxt = not_tail ? right_value : head_value;
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

[rtl/positional_list_buffer.sv]
// A request's first result sits in the output register in the cycle after acceptance.
// Insert, delete and rejected requests: one result each, back to back while results are taken.
// Show: one entry per cycle while results are taken, from the head cell as the row rotates, length entries in all.
// The next request is taken once the last result of the previous one has been loaded.
// Reset (synchronous, rst_n low) empties the list and drops any pending result;
// cell contents are not cleared and need no sweep.
module positional_list_buffer
  import plb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic                     out_last
);

  state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [LEN_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_entry_r;
  logic                     out_last_r;

  logic                     out_free;
  logic                     accept;
  logic                     issue;
  logic [1:0]               issue_status;
  logic signed [DATA_W-1:0] issue_entry;
  logic                     issue_last;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         len_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign pos_ext  = CMP_W'(in_position);
  assign len_ext  = CMP_W'(len_r);

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    issue        = 1'b0;
    issue_status = STAT_OK;
    issue_entry  = '0;
    issue_last   = 1'b1;
    cmd.op       = OP_HOLD;
    cmd.pos      = IDX_W'(in_position - POS_W'(1));
    cmd.len      = len_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          issue = 1'b1;
          unique case (in_func)
            FUNC_INSERT: begin
              if (len_r == LEN_W'(CAPACITY)) begin
                issue_status = STAT_FULL;
              end else if (pos_ext == '0 || pos_ext > len_ext + CMP_W'(1)) begin
                issue_status = STAT_RANGE;
              end else begin
                cmd.op  = OP_INSERT;
                len_nxt = len_r + LEN_W'(1);
              end
            end
            FUNC_DELETE: begin
              if (len_r == '0) begin
                issue_status = STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > len_ext) begin
                issue_status = STAT_RANGE;
              end else begin
                cmd.op  = OP_DELETE;
                len_nxt = len_r - LEN_W'(1);
              end
            end
            FUNC_SHOW: begin
              if (len_r == '0) begin
                issue_status = STAT_EMPTY;
              end else begin
                // emit the head now, rotate, continue if more remain
                issue_entry = cell_value[0];
                issue_last  = (len_r == LEN_W'(1));
                cmd.op      = OP_ROTATE;
                cnt_nxt     = LEN_W'(1);
                if (len_r != LEN_W'(1)) begin
                  state_nxt = ST_SHOW;
                end
              end
            end
            default: issue_status = STAT_RANGE;
          endcase
        end
      end
      ST_SHOW: begin
        if (out_free) begin
          issue       = 1'b1;
          issue_entry = cell_value[0];
          issue_last  = (cnt_r + LEN_W'(1) == len_r);
          cmd.op      = OP_ROTATE;
          cnt_nxt     = cnt_r + LEN_W'(1);
          if (issue_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_status_r <= issue_status;
      out_entry_r  <= issue_entry;
      out_last_r   <= issue_last;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = cell_value[g];
    end else begin : g_inner_l
      assign left_value = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[g];
    end else begin : g_inner_r
      assign right_value = cell_value[g+1];
    end

    plb_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(g)),
      .cmd         (cmd),
      .ins_value   (in_item_value),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_value[0]),
      .value       (cell_value[g])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_entry_r;
  assign out_last        = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHOW |-> len_r != '0 && cnt_r < len_r)
    else $error("show running past the list");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request gave no result");

  a_show_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHOW |-> in_stall)
    else $error("request taken during show");

  a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHOW |=> $stable(len_r))
    else $error("length changed during show");

endmodule
